// ----- rtl/wcss_pkg.sv -----
// Package for the wash-cycle stepper sequencer: codes, register map,
// configuration and result types. No dependencies.
package wcss_pkg;

  localparam int unsigned TurnW  = 10;
  localparam int unsigned TickW  = 3;
  localparam int unsigned CoilW  = 4;
  localparam int unsigned FlagW  = 5;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [TurnW-1:0] NormalTurnsRst   = 10'd1000;
  localparam logic [TurnW-1:0] PrewashTurnsRst  = 10'd300;
  localparam logic [TurnW-1:0] SpinTurnsRst     = 10'd500;
  localparam logic [TickW-1:0] WashSlowTicksRst = 3'd5;
  localparam logic [TickW-1:0] SpinSlowTicksRst = 3'd2;
  localparam logic [TickW-1:0] FastTicksRst     = 3'd1;

  // Button flag bit positions.
  localparam int unsigned BtnPower   = 0;
  localparam int unsigned BtnSpeed   = 1;
  localparam int unsigned BtnNormal  = 2;
  localparam int unsigned BtnPrewash = 3;
  localparam int unsigned BtnSpin    = 4;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_BUTTON = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PROG_NONE    = 2'd0,
    PROG_NORMAL  = 2'd1,
    PROG_PREWASH = 2'd2,
    PROG_SPIN    = 2'd3
  } prog_e;

  typedef enum logic [2:0] {
    REG_NORMAL_TURNS    = 3'd0,
    REG_PREWASH_TURNS   = 3'd1,
    REG_SPIN_TURNS      = 3'd2,
    REG_WASH_SLOW_TICKS = 3'd3,
    REG_SPIN_SLOW_TICKS = 3'd4,
    REG_FAST_TICKS      = 3'd5
  } reg_e;

  typedef struct packed {
    logic [TurnW-1:0] normal_turns;
    logic [TurnW-1:0] prewash_turns;
    logic [TurnW-1:0] spin_turns;
    logic [TickW-1:0] wash_slow_ticks;
    logic [TickW-1:0] spin_slow_ticks;
    logic [TickW-1:0] fast_ticks;
  } cfg_t;

  typedef struct packed {
    logic [CoilW-1:0] coil_drive;
    logic             power_on;
    logic             slow_mode;
    logic             running;
    logic [1:0]       selected_program;
  } res_t;

endpackage

// ----- rtl/wcss_if.sv -----
// Valid/ready channel interfaces for input words and result words.
// Depends on nothing; widths match wcss_pkg.
interface wcss_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [4:0] button_flags;

  modport source (output valid, output opcode, output button_flags, input ready);
  modport sink (input valid, input opcode, input button_flags, output ready);
endinterface

interface wcss_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] coil_drive;
  logic       power_on;
  logic       slow_mode;
  logic       running;
  logic [1:0] selected_program;

  modport source (output valid, output coil_drive, output power_on, output slow_mode,
                  output running, output selected_program, input ready);
  modport sink (input valid, input coil_drive, input power_on, input slow_mode,
                input running, input selected_program, output ready);
endinterface

// ----- rtl/wash_cycle_stepper_sequencer_top.sv -----
// Wash-cycle stepper sequencer, top level.
// An accepted input word reaches its result word through the input, then the result register.
// Throughput is one word per cycle while result_o.ready holds, limited by the state update.
// Input and result registers decouple both sides, so one word is taken while a result waits.
// Reset (rst_ni low, asynchronous) clears the pipeline, the state and loads register defaults.
// Depends on wcss_pkg, wcss_if, wcss_cfg and wcss_core.
module wash_cycle_stepper_sequencer_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  wcss_in_if.sink                    item_i,
  wcss_out_if.source                 result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wcss_pkg::AddrW-1:0] paddr,
  input  logic [wcss_pkg::DataW-1:0] pwdata,
  output logic [wcss_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import wcss_pkg::*;

  logic             in_valid_q;
  logic             opcode_q;
  logic [FlagW-1:0] flags_q;
  logic             out_valid_q;
  res_t             res_q;
  res_t             res;
  cfg_t             cfg;
  logic             fire;

  assign pready = 1'b1;

  wcss_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // A word moves from the input register into the result register when the latter
  // is empty or being drained in the same cycle.
  assign fire         = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || fire;

  wcss_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (fire),
    .opcode_i (opcode_q),
    .flags_i  (flags_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_i.ready) in_valid_q <= item_i.valid;
      if (fire) out_valid_q <= 1'b1;
      else if (result_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      opcode_q <= item_i.opcode;
      flags_q  <= item_i.button_flags;
    end
    if (fire) res_q <= res;
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.coil_drive       = res_q.coil_drive;
  assign result_o.power_on         = res_q.power_on;
  assign result_o.slow_mode        = res_q.slow_mode;
  assign result_o.running          = res_q.running;
  assign result_o.selected_program = res_q.selected_program;
endmodule

// ----- rtl/wcss_cfg.sv -----
// APB-style configuration register file for the sequencer.
// Depends on wcss_pkg.
module wcss_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wcss_pkg::AddrW-1:0] paddr,
  input  logic [wcss_pkg::DataW-1:0] pwdata,
  output logic [wcss_pkg::DataW-1:0] prdata,
  output wcss_pkg::cfg_t             cfg_o
);
  import wcss_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e idx;
  logic wr_en;

  assign idx   = reg_e'(paddr[AddrW-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_NORMAL_TURNS:    cfg_d.normal_turns    = pwdata[TurnW-1:0];
        REG_PREWASH_TURNS:   cfg_d.prewash_turns   = pwdata[TurnW-1:0];
        REG_SPIN_TURNS:      cfg_d.spin_turns      = pwdata[TurnW-1:0];
        REG_WASH_SLOW_TICKS: cfg_d.wash_slow_ticks = pwdata[TickW-1:0];
        REG_SPIN_SLOW_TICKS: cfg_d.spin_slow_ticks = pwdata[TickW-1:0];
        REG_FAST_TICKS:      cfg_d.fast_ticks      = pwdata[TickW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NORMAL_TURNS:    prdata = DataW'(cfg_q.normal_turns);
      REG_PREWASH_TURNS:   prdata = DataW'(cfg_q.prewash_turns);
      REG_SPIN_TURNS:      prdata = DataW'(cfg_q.spin_turns);
      REG_WASH_SLOW_TICKS: prdata = DataW'(cfg_q.wash_slow_ticks);
      REG_SPIN_SLOW_TICKS: prdata = DataW'(cfg_q.spin_slow_ticks);
      REG_FAST_TICKS:      prdata = DataW'(cfg_q.fast_ticks);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal_turns    <= NormalTurnsRst;
      cfg_q.prewash_turns   <= PrewashTurnsRst;
      cfg_q.spin_turns      <= SpinTurnsRst;
      cfg_q.wash_slow_ticks <= WashSlowTicksRst;
      cfg_q.spin_slow_ticks <= SpinSlowTicksRst;
      cfg_q.fast_ticks      <= FastTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ----- rtl/wcss_core.sv -----
// Sequencer state and the single-pass update for one word (tick or button).
// Depends on wcss_pkg.
module wcss_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       opcode_i,
  input  logic [wcss_pkg::FlagW-1:0] flags_i,
  input  wcss_pkg::cfg_t             cfg_i,
  output wcss_pkg::res_t             res_o
);
  import wcss_pkg::*;

  logic             power_q, power_d;
  logic             slow_q, slow_d;
  prog_e            sel_q, sel_d;
  logic             run_q, run_d;
  prog_e            rprog_q, rprog_d;
  logic             left_q, left_d;
  logic [TurnW-1:0] turns_q, turns_d;
  logic [1:0]       phase_q, phase_d;
  logic [TickW-1:0] pticks_q, pticks_d;
  logic [TickW-1:0] tpp_q, tpp_d;

  logic [CoilW-1:0] coil;
  logic [TickW-1:0] tick_sel;
  logic [TickW-1:0] pt_inc;
  logic [TurnW-1:0] rlim, llim;

  function automatic logic [CoilW-1:0] pattern(logic left, logic [1:0] ph);
    logic [CoilW-1:0] p;
    if (left) p = CoilW'(1) << ph;
    else      p = CoilW'(8) >> ph;
    return p;
  endfunction

  always_comb begin
    power_d  = power_q;
    slow_d   = slow_q;
    sel_d    = sel_q;
    run_d    = run_q;
    rprog_d  = rprog_q;
    left_d   = left_q;
    turns_d  = turns_q;
    phase_d  = phase_q;
    pticks_d = pticks_q;
    tpp_d    = tpp_q;
    coil     = '0;
    tick_sel = '0;
    pt_inc   = '0;
    rlim     = '0;
    llim     = '0;

    if (op_e'(opcode_i) == OP_BUTTON) begin
      power_d = power_q ^ flags_i[BtnPower];
      if (power_d) begin
        slow_d = slow_q ^ flags_i[BtnSpeed];
        priority if (flags_i[BtnSpin])    sel_d = PROG_SPIN;
        else if (flags_i[BtnPrewash])     sel_d = PROG_PREWASH;
        else if (flags_i[BtnNormal])      sel_d = PROG_NORMAL;
        else                              sel_d = sel_q;
      end
      coil = run_q ? pattern(left_q, phase_q) : '0;
    end else if (run_q || sel_q != PROG_NONE) begin
      if (!run_q) begin
        // Start tick: latch program and phase length, then fall into the turn start.
        run_d   = 1'b1;
        rprog_d = sel_q;
        if (slow_q) tick_sel = (sel_q == PROG_SPIN) ? cfg_i.spin_slow_ticks
                                                    : cfg_i.wash_slow_ticks;
        else        tick_sel = cfg_i.fast_ticks;
        tpp_d    = (tick_sel == '0) ? TickW'(1) : tick_sel;
        left_d   = 1'b0;
        turns_d  = '0;
        phase_d  = '0;
        pticks_d = '0;
      end

      unique case (rprog_d)
        PROG_NORMAL:  begin rlim = cfg_i.normal_turns;  llim = cfg_i.normal_turns;  end
        PROG_PREWASH: begin rlim = cfg_i.prewash_turns; llim = cfg_i.prewash_turns; end
        PROG_SPIN:    begin rlim = cfg_i.spin_turns;    llim = '0;                  end
        default:      begin rlim = '0;                  llim = '0;                  end
      endcase

      if (phase_d == '0 && pticks_d == '0) begin
        if (!left_d && turns_d >= rlim) begin
          left_d  = 1'b1;
          turns_d = '0;
        end
        if ((left_d && turns_d >= llim) || !power_q) begin
          run_d    = 1'b0;
          left_d   = 1'b0;
          turns_d  = '0;
          phase_d  = '0;
          pticks_d = '0;
          sel_d    = PROG_NONE;
        end
      end

      if (run_d) begin
        coil   = pattern(left_d, phase_d);
        pt_inc = pticks_d + TickW'(1);
        if (pt_inc >= tpp_d || pt_inc == '0) begin
          pticks_d = '0;
          phase_d  = phase_d + 2'd1;
          if (phase_d == '0) turns_d = turns_d + TurnW'(1);
        end else begin
          pticks_d = pt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q  <= 1'b0;
      slow_q   <= 1'b0;
      sel_q    <= PROG_NONE;
      run_q    <= 1'b0;
      rprog_q  <= PROG_NONE;
      left_q   <= 1'b0;
      turns_q  <= '0;
      phase_q  <= '0;
      pticks_q <= '0;
      tpp_q    <= TickW'(1);
    end else if (step_i) begin
      power_q  <= power_d;
      slow_q   <= slow_d;
      sel_q    <= sel_d;
      run_q    <= run_d;
      rprog_q  <= rprog_d;
      left_q   <= left_d;
      turns_q  <= turns_d;
      phase_q  <= phase_d;
      pticks_q <= pticks_d;
      tpp_q    <= tpp_d;
    end
  end

  assign res_o.coil_drive       = coil;
  assign res_o.power_on         = power_d;
  assign res_o.slow_mode        = slow_d;
  assign res_o.running          = run_d;
  assign res_o.selected_program = sel_d;
endmodule

// ----- dv/wcss_checker.sv -----
// Scoreboard for the wash-cycle stepper sequencer: follows the register file through
// the APB port, predicts one result word per input word and compares them in order.
// Depends on wcss_pkg and the channel interfaces in wcss_if.
module wcss_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  wcss_in_if                         item_ch,
  wcss_out_if                        result_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wcss_pkg::AddrW-1:0] paddr,
  input  logic [wcss_pkg::DataW-1:0] pwdata,
  input  logic [wcss_pkg::DataW-1:0] prdata,
  input  logic                       pready,
  output int                         errors_o,
  output int                         pending_o,
  output int                         runs_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wcss_pkg::*;

  localparam int MaxReports = 10;

  cfg_t             cfg;
  logic             pwr_on, slow_on, running, leftward;
  prog_e            chosen, latched;
  logic [TurnW-1:0] turns_done;
  logic [1:0]       coil_step;
  logic [TickW-1:0] ticks_held, ticks_needed;
  res_t             expected_q[$];
  int               errors = 0;
  int               words_checked = 0;
  int               runs_ended = 0;

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= MaxReports) $display("%0t ns: %s", $time, msg);
  endfunction

  function automatic logic [DataW-1:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_NORMAL_TURNS:    return DataW'(cfg.normal_turns);
      REG_PREWASH_TURNS:   return DataW'(cfg.prewash_turns);
      REG_SPIN_TURNS:      return DataW'(cfg.spin_turns);
      REG_WASH_SLOW_TICKS: return DataW'(cfg.wash_slow_ticks);
      REG_SPIN_SLOW_TICKS: return DataW'(cfg.spin_slow_ticks);
      REG_FAST_TICKS:      return DataW'(cfg.fast_ticks);
      default:             return '0;
    endcase
  endfunction

  function automatic void store_reg(input logic [2:0] idx, input logic [DataW-1:0] value);
    case (idx)
      REG_NORMAL_TURNS:    cfg.normal_turns = value[TurnW-1:0];
      REG_PREWASH_TURNS:   cfg.prewash_turns = value[TurnW-1:0];
      REG_SPIN_TURNS:      cfg.spin_turns = value[TurnW-1:0];
      REG_WASH_SLOW_TICKS: cfg.wash_slow_ticks = value[TickW-1:0];
      REG_SPIN_SLOW_TICKS: cfg.spin_slow_ticks = value[TickW-1:0];
      REG_FAST_TICKS:      cfg.fast_ticks = value[TickW-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [CoilW-1:0] coil_pattern();
    return leftward ? (4'b0001 << coil_step) : (4'b1000 >> coil_step);
  endfunction

  // Spin has right turns only, so its left limit is zero.
  function automatic logic [TurnW-1:0] turn_limit(input logic left_side);
    case (latched)
      PROG_NORMAL:  return cfg.normal_turns;
      PROG_PREWASH: return cfg.prewash_turns;
      PROG_SPIN:    return left_side ? '0 : cfg.spin_turns;
      default:      return '0;
    endcase
  endfunction

  function automatic logic [CoilW-1:0] advance_tick();
    logic [CoilW-1:0] coil;
    if (!running) begin
      if (chosen == PROG_NONE) return '0;
      running = 1'b1;
      latched = chosen;
      if (slow_on) begin
        ticks_needed = (chosen == PROG_SPIN) ? cfg.spin_slow_ticks : cfg.wash_slow_ticks;
      end else begin
        ticks_needed = cfg.fast_ticks;
      end
      if (ticks_needed == '0) ticks_needed = TickW'(1);
      leftward = 1'b0;
      turns_done = '0;
      coil_step = '0;
      ticks_held = '0;
    end
    // At a turn start the direction may flip, and the run may end right here.
    if (coil_step == '0 && ticks_held == '0) begin
      if (!leftward && turns_done >= turn_limit(1'b0)) begin
        leftward = 1'b1;
        turns_done = '0;
      end
      if ((leftward && turns_done >= turn_limit(1'b1)) || !pwr_on) begin
        running = 1'b0;
        leftward = 1'b0;
        turns_done = '0;
        coil_step = '0;
        ticks_held = '0;
        chosen = PROG_NONE;
        runs_ended++;
        return '0;
      end
    end
    coil = coil_pattern();
    ticks_held = ticks_held + TickW'(1);
    if (ticks_held >= ticks_needed || ticks_held == '0) begin
      ticks_held = '0;
      coil_step = coil_step + 2'd1;
      if (coil_step == '0) turns_done = turns_done + TurnW'(1);
    end
    return coil;
  endfunction

  function automatic res_t apply_word(input op_e op, input logic [FlagW-1:0] flags);
    res_t r;
    if (op == OP_BUTTON) begin
      if (flags[BtnPower]) pwr_on = !pwr_on;
      if (pwr_on) begin
        if (flags[BtnSpeed]) slow_on = !slow_on;
        if (flags[BtnNormal]) chosen = PROG_NORMAL;
        if (flags[BtnPrewash]) chosen = PROG_PREWASH;
        if (flags[BtnSpin]) chosen = PROG_SPIN;
      end
      r.coil_drive = running ? coil_pattern() : '0;
    end else begin
      r.coil_drive = advance_tick();
    end
    r.power_on = pwr_on;
    r.slow_mode = slow_on;
    r.running = running;
    r.selected_program = chosen;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    logic [2:0] reg_idx;
    if (!rst_ni) begin
      cfg = '{normal_turns: NormalTurnsRst, prewash_turns: PrewashTurnsRst,
              spin_turns: SpinTurnsRst, wash_slow_ticks: WashSlowTicksRst,
              spin_slow_ticks: SpinSlowTicksRst, fast_ticks: FastTicksRst};
      pwr_on = 1'b0;
      slow_on = 1'b0;
      running = 1'b0;
      leftward = 1'b0;
      chosen = PROG_NONE;
      latched = PROG_NONE;
      turns_done = '0;
      coil_step = '0;
      ticks_held = '0;
      ticks_needed = TickW'(1);
      expected_q.delete();
    end else begin
      reg_idx = paddr[AddrW-1:2];
      if (psel && penable && pready) begin
        if (pwrite) begin
          store_reg(reg_idx, pwdata);
        end else if (reg_idx <= REG_FAST_TICKS && prdata !== reg_value(reg_idx)) begin
          flag_error($sformatf("register %0d read back %h, expected %h",
                               reg_idx, prdata, reg_value(reg_idx)));
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        expected_q.push_back(apply_word(op_e'(item_ch.opcode), item_ch.button_flags));
      end
      if (result_ch.valid && result_ch.ready) begin
        words_checked++;
        if (expected_q.size() == 0) begin
          flag_error($sformatf("result word %0d arrived with nothing expected", words_checked));
        end else begin
          want = expected_q.pop_front();
          if (result_ch.coil_drive !== want.coil_drive || result_ch.power_on !== want.power_on
              || result_ch.slow_mode !== want.slow_mode || result_ch.running !== want.running
              || result_ch.selected_program !== want.selected_program) begin
            flag_error($sformatf({"result word %0d: expected coil %b power %b slow %b run %b ",
                                  "prog %0d, got coil %b power %b slow %b run %b prog %0d"},
                                 words_checked, want.coil_drive, want.power_on,
                                 want.slow_mode, want.running, want.selected_program,
                                 result_ch.coil_drive, result_ch.power_on,
                                 result_ch.slow_mode, result_ch.running,
                                 result_ch.selected_program));
          end
        end
      end
    end
    errors_o <= errors;
    pending_o <= expected_q.size();
    runs_o <= runs_ended;
  end

endmodule

// ----- dv/testbench.sv -----
// Top of the wash-cycle sequencer regression: clock, reset, button and tick stimulus,
// register settings over APB and the verdict. Depends on the whole rtl and wcss_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wcss_pkg::*;

  localparam int ItemTarget = 1300;
  localparam int PhaseCount = 9;
  localparam int CycleLimit = 400_000;
  localparam int MaxGap     = 12;
  localparam int SpanCap    = 150;

  localparam logic [2:0] SpareRegLo = 3'd6;
  localparam logic [2:0] SpareRegHi = 3'd7;

  localparam logic [FlagW-1:0] PowerBtn   = FlagW'(1) << BtnPower;
  localparam logic [FlagW-1:0] SpeedBtn   = FlagW'(1) << BtnSpeed;
  localparam logic [FlagW-1:0] NormalBtn  = FlagW'(1) << BtnNormal;
  localparam logic [FlagW-1:0] PrewashBtn = FlagW'(1) << BtnPrewash;
  localparam logic [FlagW-1:0] SpinBtn    = FlagW'(1) << BtnSpin;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata, prdata;
  int               errors, pending, runs;
  int               cycles = 0;
  int               words_sent = 0;
  int               ticks_sent = 0;
  int               buttons_sent = 0;
  int               reads_done = 0;
  int               settings = 1;
  int               span = SpanCap;
  bit               gaps_on = 1'b1;
  logic             power_shadow = 1'b0;

  wcss_in_if  item_if();
  wcss_out_if result_if();

  wash_cycle_stepper_sequencer_top dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_if),
    .result_o(result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  wcss_checker result_check (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_ch  (item_if),
    .result_ch(result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .errors_o (errors),
    .pending_o(pending),
    .runs_o   (runs)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d result words still expected.", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(input op_e op, input logic [FlagW-1:0] flags);
    int gap;
    gap = gaps_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.opcode <= op;
    item_if.button_flags <= flags;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    words_sent++;
    if (op == OP_BUTTON) begin
      buttons_sent++;
      if (flags[BtnPower]) power_shadow = !power_shadow;
    end else begin
      ticks_sent++;
    end
  endtask

  // Leaves psel high so that transfers can follow back to back.
  task automatic apb_transfer(input bit wr, input logic [2:0] idx,
                              input logic [DataW-1:0] value);
    psel <= 1'b1;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    if (!wr) reads_done++;
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_phase(input int nt, pt, st, ws, ss, ft, input bit junk, input bit spare);
    int longest, slowest;
    apb_transfer(1'b1, REG_NORMAL_TURNS, junk ? {22'($urandom()), 10'(nt)} : DataW'(nt));
    apb_transfer(1'b1, REG_PREWASH_TURNS, junk ? {22'($urandom()), 10'(pt)} : DataW'(pt));
    apb_transfer(1'b1, REG_SPIN_TURNS, junk ? {22'($urandom()), 10'(st)} : DataW'(st));
    apb_transfer(1'b1, REG_WASH_SLOW_TICKS, junk ? {29'($urandom()), 3'(ws)} : DataW'(ws));
    apb_transfer(1'b1, REG_SPIN_SLOW_TICKS, junk ? {29'($urandom()), 3'(ss)} : DataW'(ss));
    apb_transfer(1'b1, REG_FAST_TICKS, junk ? {29'($urandom()), 3'(ft)} : DataW'(ft));
    if (spare) begin
      apb_transfer(1'b1, SpareRegLo, $urandom());
      apb_transfer(1'b1, SpareRegHi, $urandom());
    end
    for (int r = REG_NORMAL_TURNS; r <= REG_FAST_TICKS; r++) apb_transfer(1'b0, 3'(r), '0);
    psel <= 1'b0;
    settings++;
    // Enough ticks for the longest possible run under this setting, capped.
    longest = nt;
    if (pt > longest) longest = pt;
    if (st > longest) longest = st;
    slowest = 1;
    if (ws > slowest) slowest = ws;
    if (ss > slowest) slowest = ss;
    if (ft > slowest) slowest = ft;
    span = 8 * longest * slowest + 4;
    if (span > SpanCap) span = SpanCap;
  endtask

  function automatic int draw_turns();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 12);
  endfunction

  task automatic exercise(input int quota);
    int start, n;
    start = words_sent;
    while (words_sent - start < quota) begin
      gaps_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_word(op_e'($urandom_range(0, 1)), FlagW'($urandom()));
        end
      end else begin
        // A wash episode: power up if needed, pick a program, then send it a random run of ticks.
        if (!power_shadow) send_word(OP_BUTTON, {4'($urandom()), 1'b1});
        send_word(OP_BUTTON, {3'($urandom_range(1, 7)), 1'($urandom()), 1'b0});
        n = $urandom_range(1, span);
        // The last episode of a phase stops at the phase's share of words.
        if (n > quota - (words_sent - start)) n = quota - (words_sent - start);
        if (n < 1) n = 1;
        repeat (n) begin
          if ($urandom_range(0, 29) == 0) send_word(OP_BUTTON, FlagW'($urandom()));
          else send_word(OP_TICK, FlagW'($urandom()));
        end
      end
    end
  endtask

  initial begin : result_pacing
    int stall;
    result_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, MaxGap) : 0;
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      @(posedge clk);
      while (!result_if.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int quota;
    item_if.valid = 1'b0;
    item_if.opcode = OP_TICK;
    item_if.button_flags = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Other buttons are ignored while power is off; spin beats prewash beats normal.
    send_word(OP_TICK, '0);
    send_word(OP_BUTTON, SpeedBtn | NormalBtn | PrewashBtn | SpinBtn);
    send_word(OP_BUTTON, PowerBtn);
    send_word(OP_BUTTON, SpeedBtn | NormalBtn | PrewashBtn | SpinBtn);
    send_word(OP_BUTTON, SpeedBtn | NormalBtn | PrewashBtn);
    send_word(OP_BUTTON, NormalBtn);
    // Normal run at full speed; a new selection mid-run must not change it.
    repeat (3) send_word(OP_TICK, '0);
    send_word(OP_BUTTON, SpinBtn);
    send_word(OP_TICK, '0);
    // Power off only takes effect at the next turn start.
    send_word(OP_BUTTON, PowerBtn);
    send_word(OP_TICK, '1);
    // All buttons at once: power on, slow, spin.
    send_word(OP_BUTTON, '1);
    repeat (3) send_word(OP_TICK, '0);
    send_word(OP_BUTTON, PowerBtn | SpeedBtn);
    repeat (6) send_word(OP_TICK, '0);
    // A run latched with power already off starts and ends on the same tick.
    send_word(OP_BUTTON, PowerBtn | PrewashBtn);
    send_word(OP_BUTTON, PowerBtn);
    send_word(OP_TICK, '0);

    quota = ItemTarget / PhaseCount;
    exercise(quota);
    drain();
    set_phase(0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    exercise(quota);
    drain();
    set_phase(1023, 1023, 1023, 7, 7, 7, 1'b0, 1'b0);
    exercise(quota);
    drain();
    set_phase(1, 1, 1, 1, 1, 1, 1'b0, 1'b0);
    exercise(quota);
    for (int i = 0; i < PhaseCount - 4; i++) begin
      drain();
      set_phase(draw_turns(), draw_turns(), draw_turns(), $urandom_range(0, 7),
                $urandom_range(0, 7), $urandom_range(0, 7), 1'b1, i == 0);
      exercise(quota);
    end
    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d input words (%0d ticks, %0d button events) under %0d register settings.",
             words_sent, ticks_sent, buttons_sent, settings);
    $display("%0d wash runs reached their end; %0d register reads were compared.",
             runs, reads_done);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- wash_cycle_stepper_sequencer_top.f -----
rtl/wcss_pkg.sv
rtl/wcss_if.sv
rtl/wcss_cfg.sv
rtl/wcss_core.sv
rtl/wash_cycle_stepper_sequencer_top.sv
dv/wcss_checker.sv
dv/testbench.sv
